// ----- design/ggpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared widths, pipeline depths, register indexes and the CORDIC angle table
// for the go-to-goal proportional controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;

    localparam int POS_W       = 15;
    localparam int HDG_W       = 16;
    localparam int DIFF_W      = POS_W + 1;
    localparam int LIN_W       = 17;
    localparam int ANG_W       = 19;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int XW            = 28;
    localparam int ZW            = 20;
    localparam int HALF_PI_Q16   = 102944;
    localparam int BEAR_W        = ZW - 3;

    localparam int SQ_W       = 2 * POS_W + 1;
    localparam int SQRT_STEPS = 16;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = 2 * SQRT_STEPS;

    localparam int FRONT_STAGES = 3;
    localparam int CORE_DEPTH   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int NUM_STAGES   = FRONT_STAGES + CORE_DEPTH + 1;

    localparam int ANG_MAX = 205888;

    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_X     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GOAL_Y     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ARRIVE_TOL = 2'd2;

    localparam logic [POS_W-1:0] GOAL_X_RST     = 15'd2048;
    localparam logic [POS_W-1:0] GOAL_Y_RST     = 15'd2048;
    localparam logic [POS_W-1:0] ARRIVE_TOL_RST = 15'd20;

    typedef struct packed {
        logic [SQ_W-1:0]         sq;
        logic                    arrived;
        logic signed [HDG_W-1:0] heading;
        logic signed [XW-1:0]    cx;
        logic signed [XW-1:0]    cy;
        logic signed [ZW-1:0]    cz;
    } front_t;

    // atan(2^-i) in Q.16 radians
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            16:      a = 20'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/ggpc_front.sv -----
// ----------------------------------------------------------------------------
// ggpc_front
// Three pipeline stages: goal deltas, squares and quadrant pre-rotation,
// squared distance and arrival compare.
// ----------------------------------------------------------------------------
module ggpc_front (
    input  logic                                    clk,
    input  logic [ggpc_pkg::FRONT_STAGES-1:0]       en,
    input  logic [ggpc_pkg::POS_W-1:0]              goal_x,
    input  logic [ggpc_pkg::POS_W-1:0]              goal_y,
    input  logic [ggpc_pkg::POS_W-1:0]              arrive_tolerance,
    input  logic [ggpc_pkg::POS_W-1:0]              pose_x,
    input  logic [ggpc_pkg::POS_W-1:0]              pose_y,
    input  logic signed [ggpc_pkg::HDG_W-1:0]       pose_heading,
    output ggpc_pkg::front_t                        front
);

    logic signed [ggpc_pkg::DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [ggpc_pkg::HDG_W-1:0]   hd1_reg, hd2_reg;

    logic [2*ggpc_pkg::POS_W-1:0]        dxsq_reg, dysq_reg, tolsq_reg;
    logic signed [ggpc_pkg::XW-1:0]      cx_reg, cy_reg;
    logic signed [ggpc_pkg::ZW-1:0]      cz_reg;

    logic signed [2*ggpc_pkg::DIFF_W-1:0] prod_x, prod_y;
    logic [2*ggpc_pkg::POS_W-1:0]         tol_sq;
    logic signed [ggpc_pkg::XW-1:0]       x256, y256;
    logic signed [ggpc_pkg::XW-1:0]       cx_next, cy_next;
    logic signed [ggpc_pkg::ZW-1:0]       cz_next;
    logic [ggpc_pkg::SQ_W-1:0]            sq_sum;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg  <= $signed({1'b0, goal_x}) - $signed({1'b0, pose_x});
            dy_reg  <= $signed({1'b0, goal_y}) - $signed({1'b0, pose_y});
            hd1_reg <= pose_heading;
        end
    end

    always_comb
    begin
        prod_x = (2*ggpc_pkg::DIFF_W)'(dx_reg) * (2*ggpc_pkg::DIFF_W)'(dx_reg);
        prod_y = (2*ggpc_pkg::DIFF_W)'(dy_reg) * (2*ggpc_pkg::DIFF_W)'(dy_reg);
        tol_sq = (2*ggpc_pkg::POS_W)'(arrive_tolerance)
               * (2*ggpc_pkg::POS_W)'(arrive_tolerance);
        x256   = ggpc_pkg::XW'(dx_reg) <<< 8;
        y256   = ggpc_pkg::XW'(dy_reg) <<< 8;
        cx_next = x256;
        cy_next = y256;
        cz_next = '0;
        if (dx_reg < 0)
        begin
            if (dy_reg >= 0)
            begin
                cx_next = y256;
                cy_next = -x256;
                cz_next = ggpc_pkg::ZW'(ggpc_pkg::HALF_PI_Q16);
            end
            else
            begin
                cx_next = -y256;
                cy_next = x256;
                cz_next = -ggpc_pkg::ZW'(ggpc_pkg::HALF_PI_Q16);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dxsq_reg  <= prod_x[2*ggpc_pkg::POS_W-1:0];
            dysq_reg  <= prod_y[2*ggpc_pkg::POS_W-1:0];
            tolsq_reg <= tol_sq;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            hd2_reg   <= hd1_reg;
        end
    end

    assign sq_sum = ggpc_pkg::SQ_W'(dxsq_reg) + ggpc_pkg::SQ_W'(dysq_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            front.sq      <= sq_sum;
            front.arrived <= (sq_sum <= ggpc_pkg::SQ_W'(tolsq_reg));
            front.heading <= hd2_reg;
            front.cx      <= cx_reg;
            front.cy      <= cy_reg;
            front.cz      <= cz_reg;
        end
    end

endmodule

// ----- design/ggpc_isqrt.sv -----
// ----------------------------------------------------------------------------
// ggpc_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Produces the floor root and the remainder.
// ----------------------------------------------------------------------------
module ggpc_isqrt (
    input  logic                                 clk,
    input  logic [ggpc_pkg::CORE_DEPTH-1:0]      en,
    input  logic [ggpc_pkg::SQ_W-1:0]            sq_in,
    output logic [ggpc_pkg::ROOT_W-1:0]          root,
    output logic [ggpc_pkg::REM_W-1:0]           rem
);

    typedef struct packed {
        logic [ggpc_pkg::REM_W-1:0]  rem;
        logic [ggpc_pkg::ROOT_W-1:0] root;
    } sq_stage_t;

    sq_stage_t stage_reg  [ggpc_pkg::CORE_DEPTH];
    sq_stage_t stage_next [ggpc_pkg::CORE_DEPTH];

    always_comb
    begin
        sq_stage_t             cur;
        logic [ggpc_pkg::REM_W:0] trial;
        for (int j = 0; j < ggpc_pkg::CORE_DEPTH; j++)
        begin
            if (j == 0)
            begin
                cur.rem  = ggpc_pkg::REM_W'(sq_in);
                cur.root = '0;
            end
            else
            begin
                cur = stage_reg[j-1];
            end
            stage_next[j] = cur;
            trial = '0;
            if (j < ggpc_pkg::SQRT_STEPS)
            begin
                trial = ((ggpc_pkg::REM_W+1)'(cur.root) << (ggpc_pkg::SQRT_STEPS - j))
                      + ((ggpc_pkg::REM_W+1)'(1) << (2 * (ggpc_pkg::SQRT_STEPS - 1 - j)));
                if ({1'b0, cur.rem} >= trial)
                begin
                    stage_next[j].rem  = cur.rem - trial[ggpc_pkg::REM_W-1:0];
                    stage_next[j].root = cur.root
                                       | (ggpc_pkg::ROOT_W'(1) << (ggpc_pkg::SQRT_STEPS - 1 - j));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ggpc_pkg::CORE_DEPTH; j++)
        begin
            if (en[j])
                stage_reg[j] <= stage_next[j];
        end
    end

    assign root = stage_reg[ggpc_pkg::CORE_DEPTH-1].root;
    assign rem  = stage_reg[ggpc_pkg::CORE_DEPTH-1].rem;

endmodule

// ----- design/ggpc_cordic.sv -----
// ----------------------------------------------------------------------------
// ggpc_cordic
// Pipelined vectoring CORDIC for the bearing, one micro-rotation per stage,
// padded to the core depth. Carries heading and arrival flag alongside.
// ----------------------------------------------------------------------------
module ggpc_cordic (
    input  logic                                 clk,
    input  logic [ggpc_pkg::CORE_DEPTH-1:0]      en,
    input  ggpc_pkg::front_t                     front,
    output logic signed [ggpc_pkg::ZW-1:0]       z,
    output logic signed [ggpc_pkg::HDG_W-1:0]    heading,
    output logic                                 arrived
);

    typedef struct packed {
        logic signed [ggpc_pkg::XW-1:0]    x;
        logic signed [ggpc_pkg::XW-1:0]    y;
        logic signed [ggpc_pkg::ZW-1:0]    z;
        logic signed [ggpc_pkg::HDG_W-1:0] heading;
        logic                              arrived;
    } cd_stage_t;

    cd_stage_t stage_reg  [ggpc_pkg::CORE_DEPTH];
    cd_stage_t stage_next [ggpc_pkg::CORE_DEPTH];

    always_comb
    begin
        cd_stage_t                      cur;
        logic signed [ggpc_pkg::XW-1:0] xc, yc, xs, ys;
        logic signed [ggpc_pkg::ZW-1:0] zc, az;
        for (int j = 0; j < ggpc_pkg::CORE_DEPTH; j++)
        begin
            if (j == 0)
            begin
                cur.x       = front.cx;
                cur.y       = front.cy;
                cur.z       = front.cz;
                cur.heading = front.heading;
                cur.arrived = front.arrived;
            end
            else
            begin
                cur = stage_reg[j-1];
            end
            stage_next[j] = cur;
            xc = cur.x;
            yc = cur.y;
            zc = cur.z;
            xs = xc >>> j;
            ys = yc >>> j;
            az = ggpc_pkg::atan_q16(j);
            if (j < ggpc_pkg::CORDIC_STAGES && j < ggpc_pkg::ATAN_LEN)
            begin
                if (yc >= 0)
                begin
                    stage_next[j].x = xc + ys;
                    stage_next[j].y = yc - xs;
                    stage_next[j].z = zc + az;
                end
                else
                begin
                    stage_next[j].x = xc - ys;
                    stage_next[j].y = yc + xs;
                    stage_next[j].z = zc - az;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ggpc_pkg::CORE_DEPTH; j++)
        begin
            if (en[j])
                stage_reg[j] <= stage_next[j];
        end
    end

    assign z       = stage_reg[ggpc_pkg::CORE_DEPTH-1].z;
    assign heading = stage_reg[ggpc_pkg::CORE_DEPTH-1].heading;
    assign arrived = stage_reg[ggpc_pkg::CORE_DEPTH-1].arrived;

endmodule

// ----- design/go_to_goal_p_controller_core.sv -----
// Pipeline: the front stages, the core stages, then an output register.
// Throughput: one pose sample per clock while the output is not stalled; per-stage valid bits let bubbles
// collapse, so a stalled output only halts the stages that hold data.
// Depth is set by the 16-step square root and the CORDIC rotation chain.
// Reset clears all valid bits and loads the goal (2048, 2048) and
// tolerance 20; pipeline payload is not reset.
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_core
// Proportional go-to-goal controller: distance and bearing to a configured
// goal, linear command 1.5 x distance, angular command 4 x heading error.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ggpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ggpc_pkg::POS_W-1:0]          cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] pose_x, [29:15] pose_y, [45:30] pose_heading, [47:46] zero
    input  logic [ggpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] linear_cmd, [35:17] angular_cmd, [39:36] zero
    output logic [ggpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] arrived
    output logic                                m_axis_tuser
);

    localparam int NS = ggpc_pkg::NUM_STAGES;
    localparam int FS = ggpc_pkg::FRONT_STAGES;
    localparam int CD = ggpc_pkg::CORE_DEPTH;

    logic [ggpc_pkg::POS_W-1:0] goal_x_reg, goal_y_reg, tol_reg;
    logic [NS-1:0]              v_reg;
    logic [NS-1:0]              en;

    ggpc_pkg::front_t                  front;
    logic [ggpc_pkg::ROOT_W-1:0]       root;
    logic [ggpc_pkg::REM_W-1:0]        rem;
    logic signed [ggpc_pkg::ZW-1:0]    z_fin;
    logic signed [ggpc_pkg::HDG_W-1:0] hd_fin;
    logic                              arr_fin;

    logic [ggpc_pkg::ROOT_W:0]          dist_rnd;
    logic [ggpc_pkg::LIN_W:0]           lin_x3;
    logic signed [ggpc_pkg::ZW-1:0]     z_rnd;
    logic signed [ggpc_pkg::BEAR_W-1:0] bearing;
    logic signed [ggpc_pkg::HDG_W+1:0]  herr;
    logic signed [ggpc_pkg::HDG_W+3:0]  ang_x4;
    logic signed [ggpc_pkg::ANG_W-1:0]  ang_sat;

    logic [ggpc_pkg::LIN_W-1:0]         linear_reg;
    logic signed [ggpc_pkg::ANG_W-1:0]  angular_reg;
    logic                               arrived_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= ggpc_pkg::GOAL_X_RST;
            goal_y_reg <= ggpc_pkg::GOAL_Y_RST;
            tol_reg    <= ggpc_pkg::ARRIVE_TOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ggpc_pkg::REG_GOAL_X:     goal_x_reg <= cfg_wdata;
                ggpc_pkg::REG_GOAL_Y:     goal_y_reg <= cfg_wdata;
                ggpc_pkg::REG_ARRIVE_TOL: tol_reg    <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_axis_tready = en[0];

    ggpc_front u_front (
        .clk              (clk),
        .en               (en[FS-1:0]),
        .goal_x           (goal_x_reg),
        .goal_y           (goal_y_reg),
        .arrive_tolerance (tol_reg),
        .pose_x           (s_axis_tdata[14:0]),
        .pose_y           (s_axis_tdata[29:15]),
        .pose_heading     (s_axis_tdata[45:30]),
        .front            (front)
    );

    ggpc_isqrt u_isqrt (
        .clk   (clk),
        .en    (en[FS+CD-1:FS]),
        .sq_in (front.sq),
        .root  (root),
        .rem   (rem)
    );

    ggpc_cordic u_cordic (
        .clk     (clk),
        .en      (en[FS+CD-1:FS]),
        .front   (front),
        .z       (z_fin),
        .heading (hd_fin),
        .arrived (arr_fin)
    );

    always_comb
    begin
        dist_rnd = {1'b0, root}
                 + (ggpc_pkg::ROOT_W+1)'(ggpc_pkg::REM_W'(root) < rem);
        lin_x3  = {dist_rnd, 1'b0} + (ggpc_pkg::LIN_W+1)'(dist_rnd)
                + (ggpc_pkg::LIN_W+1)'(1);
        z_rnd   = z_fin + ggpc_pkg::ZW'(4);
        bearing = ggpc_pkg::BEAR_W'(z_rnd >>> 3);
        herr    = (ggpc_pkg::HDG_W+2)'(bearing) - (ggpc_pkg::HDG_W+2)'(hd_fin);
        ang_x4  = (ggpc_pkg::HDG_W+4)'(herr) <<< 2;
        if (ang_x4 > (ggpc_pkg::HDG_W+4)'(ggpc_pkg::ANG_MAX))
            ang_sat = ggpc_pkg::ANG_W'(ggpc_pkg::ANG_MAX);
        else if (ang_x4 < -(ggpc_pkg::HDG_W+4)'(ggpc_pkg::ANG_MAX))
            ang_sat = -ggpc_pkg::ANG_W'(ggpc_pkg::ANG_MAX);
        else
            ang_sat = ang_x4[ggpc_pkg::ANG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            arrived_reg <= arr_fin;
            linear_reg  <= arr_fin ? '0 : lin_x3[ggpc_pkg::LIN_W:1];
            angular_reg <= arr_fin ? '0 : ang_sat;
        end
    end

    assign m_axis_tvalid = v_reg[NS-1];
    assign m_axis_tdata  = {{(ggpc_pkg::OUT_DATA_W - ggpc_pkg::LIN_W - ggpc_pkg::ANG_W){1'b0}},
                            angular_reg, linear_reg};
    assign m_axis_tuser  = arrived_reg;

endmodule

// ----- design/ggpc_checker.sv -----
// ----------------------------------------------------------------------------
// ggpc_checker
// Port-level checks on the controller's result stream.
// ----------------------------------------------------------------------------
module ggpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("arrived result carries nonzero commands");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[35:17]) <= 19'sd205888) &&
                          ($signed(m_axis_tdata[35:17]) >= -19'sd205888))
        else $error("turn rate outside saturation range");

    a_lin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd69510) &&
                          (m_axis_tdata[39:36] == 4'd0))
        else $error("forward speed beyond reachable distance or pad bits set");

endmodule

bind go_to_goal_p_controller_core ggpc_checker u_ggpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
